// ===== rtl/key_value_table_assert.svh =====
// Assertion macros used by the key-value table checker.
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define KVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("key_value_table assertion failed");

// Check that cons holds in the cycle after ante holds.
`define KVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("key_value_table assertion failed");

`endif

// ===== rtl/kvt_pkg.sv =====
// Package for the key-value table: codes, microcode word and control store.
package kvt_pkg;

    localparam int KVT_DEPTH = 16;
    localparam int KVT_KEY_W = 32;
    localparam int KVT_VAL_W = 32;
    localparam int KVT_TOTAL_W = 5;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Sequencer steps.
    typedef enum logic [2:0] {
        S_CLR    = 3'd0,
        S_WAIT   = 3'd1,
        S_READ   = 3'd2,
        S_LOOP   = 3'd3,
        S_COMMIT = 3'd4
    } t_step;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_IN_ACC    = 3'd1,
        C_SCAN_DONE = 3'd2,
        C_CLR_DONE  = 3'd3,
        C_OUT_FREE  = 3'd4
    } t_cond;

    typedef struct packed {
        logic  in_rdy;     // take a new item
        logic  scan_init;  // rewind the slot address, drop scan results
        logic  rd_en;      // read a slot and advance
        logic  cmp_en;     // compare the slot read last cycle
        logic  clr_wr;     // clear one valid mark and advance
        logic  commit;     // apply the command and load the result
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '{in_rdy: 1'b0, scan_init: 1'b0, rd_en: 1'b0, cmp_en: 1'b0,
              clr_wr: 1'b0, commit: 1'b0, cond: C_ALWAYS,
              tgt_t: S_WAIT, tgt_f: S_WAIT};
        case (step)
            S_CLR: begin
                w.clr_wr = 1'b1;
                w.cond   = C_CLR_DONE;
                w.tgt_t  = S_WAIT;
                w.tgt_f  = S_CLR;
            end
            S_WAIT: begin
                w.in_rdy    = 1'b1;
                w.scan_init = 1'b1;
                w.cond      = C_IN_ACC;
                w.tgt_t     = S_READ;
                w.tgt_f     = S_WAIT;
            end
            S_READ: begin
                w.rd_en = 1'b1;
                w.cond  = C_ALWAYS;
                w.tgt_t = S_LOOP;
                w.tgt_f = S_LOOP;
            end
            S_LOOP: begin
                w.rd_en  = 1'b1;
                w.cmp_en = 1'b1;
                w.cond   = C_SCAN_DONE;
                w.tgt_t  = S_COMMIT;
                w.tgt_f  = S_LOOP;
            end
            S_COMMIT: begin
                w.commit = 1'b1;
                w.cond   = C_OUT_FREE;
                w.tgt_t  = S_WAIT;
                w.tgt_f  = S_COMMIT;
            end
            default: begin
                w.cond  = C_ALWAYS;
                w.tgt_t = S_CLR;
                w.tgt_f = S_CLR;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/key_value_table.sv =====
// Key-value table of DEPTH slots holding signed 32-bit keys and values. Each
// item is a put, get or remove; each gives one result item with a status, the
// value read by a get (zero otherwise) and the entry count after the command,
// taken modulo 32. A put on a held key overwrites its value, a new key takes
// the lowest free slot or reports full. Slots live in single-port memories
// with one registered read port; a small microcoded sequencer walks every
// slot once through that port, comparing one key per cycle, then writes back
// in one step. An item occupies the block from its acceptance through the
// first read, the scan and the write-back step; the next item is accepted
// only after that. A result waits in an output register, so the next item is
// accepted and scanned while it waits; only the write-back step holds for
// it. After reset a clearing pass wipes every valid mark, during which
// o_ready stays low.
module key_value_table #(
    parameter int DEPTH = kvt_pkg::KVT_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_cmd,
    input  logic signed [kvt_pkg::KVT_KEY_W-1:0] i_lookup_key,
    input  logic signed [kvt_pkg::KVT_VAL_W-1:0] i_write_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic signed [kvt_pkg::KVT_VAL_W-1:0] o_read_value,
    output logic [kvt_pkg::KVT_TOTAL_W-1:0]      o_entry_total
);
    import kvt_pkg::*;

    localparam int AW  = $clog2(DEPTH);      // slot index width
    localparam int AW1 = $clog2(DEPTH + 1);  // address counter, can hold DEPTH
    localparam int CW  = $clog2(DEPTH + 1);  // entry count

    // Slot storage: one write and one registered read per cycle.
    logic                 mem_valid [DEPTH];
    logic [KVT_KEY_W-1:0] mem_key   [DEPTH];
    logic [KVT_VAL_W-1:0] mem_value [DEPTH];

    // Sequencer.
    t_step  r_step, n_step;
    t_uword uw;
    logic   cond_true;

    // Scan address and the registered read port.
    logic [AW1-1:0]       r_addr, n_addr;
    logic                 rd_go;
    logic                 r_rd_valid;
    logic [KVT_KEY_W-1:0] r_rd_key;
    logic [KVT_VAL_W-1:0] r_rd_value;
    logic [AW-1:0]        r_rd_idx;

    // Scan results.
    logic                 r_hit, n_hit;
    logic [AW-1:0]        r_hit_idx, n_hit_idx;
    logic [KVT_VAL_W-1:0] r_hit_val, n_hit_val;
    logic                 r_free, n_free;
    logic [AW-1:0]        r_free_idx, n_free_idx;

    // Item under work.
    logic [1:0]           r_cmd;
    logic [KVT_KEY_W-1:0] r_key;
    logic [KVT_VAL_W-1:0] r_wval;

    logic [CW-1:0] r_count, n_count;

    // Result register.
    logic                 r_o_valid, n_o_valid;
    logic [1:0]           r_o_status;
    logic [KVT_VAL_W-1:0] r_o_read_value;
    logic [KVT_TOTAL_W-1:0] r_o_entry_total;

    logic in_acc, out_free, commit_go;

    // Write port.
    logic          wv_en, wv_bit, wk_en, wval_en;
    logic [AW-1:0] w_addr;
    t_status       res_status;
    logic [KVT_VAL_W-1:0] res_value;

    assign uw        = uc_rom(r_step);
    assign o_ready   = uw.in_rdy;
    assign in_acc    = i_valid && uw.in_rdy;
    assign out_free  = !r_o_valid || i_ready;
    assign commit_go = uw.commit && out_free;
    assign rd_go     = uw.rd_en && (r_addr != AW1'(DEPTH));

    // Jump condition and next step.
    always_comb begin
        case (uw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_IN_ACC:    cond_true = in_acc;
            C_SCAN_DONE: cond_true = (r_addr == AW1'(DEPTH));
            C_CLR_DONE:  cond_true = (r_addr == AW1'(DEPTH - 1));
            C_OUT_FREE:  cond_true = out_free;
            default:     cond_true = 1'b1;
        endcase
        n_step = cond_true ? uw.tgt_t : uw.tgt_f;
    end

    // Address counter: rewound while waiting, advanced by reads and clears.
    always_comb begin
        n_addr = r_addr;
        if (uw.scan_init) begin
            n_addr = '0;
        end else if (rd_go || uw.clr_wr) begin
            n_addr = r_addr + AW1'(1);
        end
    end

    // Keep the first matching slot and the lowest free slot seen so far.
    always_comb begin
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_val  = r_hit_val;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        if (uw.scan_init) begin
            n_hit  = 1'b0;
            n_free = 1'b0;
        end else if (uw.cmp_en) begin
            if (r_rd_valid && (r_rd_key == r_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_rd_idx;
                n_hit_val = r_rd_value;
            end
            if (!r_rd_valid && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_rd_idx;
            end
        end
    end

    // Write-back decision and result.
    always_comb begin
        wv_en      = 1'b0;
        wv_bit     = 1'b0;
        wk_en      = 1'b0;
        wval_en    = 1'b0;
        w_addr     = r_hit_idx;
        n_count    = r_count;
        res_status = ST_OK;
        res_value  = '0;
        if (uw.clr_wr) begin
            wv_en  = 1'b1;
            w_addr = r_addr[AW-1:0];
        end else if (commit_go) begin
            case (r_cmd)
                CMD_PUT: begin
                    if (r_hit) begin
                        wval_en = 1'b1;
                    end else if (r_free) begin
                        w_addr  = r_free_idx;
                        wv_en   = 1'b1;
                        wv_bit  = 1'b1;
                        wk_en   = 1'b1;
                        wval_en = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        res_status = ST_FULL;
                    end
                end
                CMD_GET: begin
                    if (r_hit) begin
                        res_value = r_hit_val;
                    end else begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                CMD_REMOVE: begin
                    if (r_hit) begin
                        wv_en   = 1'b1;
                        n_count = r_count - CW'(1);
                    end else begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // Result valid: load on commit, drop once taken.
    always_comb begin
        n_o_valid = r_o_valid;
        if (commit_go) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_addr    <= n_addr;
            r_hit     <= n_hit;
            r_free    <= n_free;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_hit_val  <= n_hit_val;
        r_free_idx <= n_free_idx;
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_key  <= i_lookup_key;
            r_wval <= i_write_value;
        end
        if (commit_go) begin
            r_o_status      <= res_status;
            r_o_read_value  <= res_value;
            r_o_entry_total <= KVT_TOTAL_W'(n_count);
        end
    end

    // Slot memories.
    always_ff @(posedge i_clk) begin
        if (wv_en) begin
            mem_valid[w_addr] <= wv_bit;
        end
        if (wk_en) begin
            mem_key[w_addr] <= r_key;
        end
        if (wval_en) begin
            mem_value[w_addr] <= r_wval;
        end
        if (rd_go) begin
            r_rd_valid <= mem_valid[r_addr[AW-1:0]];
            r_rd_key   <= mem_key[r_addr[AW-1:0]];
            r_rd_value <= mem_value[r_addr[AW-1:0]];
            r_rd_idx   <= r_addr[AW-1:0];
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_read_value;
    assign o_entry_total = r_o_entry_total;

endmodule

// ===== rtl/kvt_checker.sv =====
// Port-level checker for the key-value table, bound to the top level.
`include "key_value_table_assert.svh"

module kvt_checker #(
    parameter int DEPTH = kvt_pkg::KVT_DEPTH
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [1:0]                           o_status,
    input logic signed [kvt_pkg::KVT_VAL_W-1:0] o_read_value,
    input logic [kvt_pkg::KVT_TOTAL_W-1:0]      o_entry_total
);
    import kvt_pkg::*;

    localparam logic [KVT_TOTAL_W-1:0] FULL_TOTAL = KVT_TOTAL_W'(DEPTH);

    // Full is reported only when every slot is taken.
    `KVT_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), (o_entry_total == FULL_TOTAL))

    // A failed command reads back zero.
    `KVT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_read_value == '0))

    // Count never passes the table size.
    `KVT_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_valid, (DEPTH > 31) || (o_entry_total <= FULL_TOTAL))

    // A stalled result holds.
    `KVT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_read_value) && $stable(o_entry_total))

endmodule

bind key_value_table kvt_checker #(.DEPTH(DEPTH)) u_kvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_read_value  (o_read_value),
    .o_entry_total (o_entry_total)
);
